// File: rtl/pbaag_pkg.sv
package pbaag_pkg;

   localparam int P_DEFAULT    = 2;
   localparam int Q_DEFAULT    = 4;
   localparam int ROWS_DEFAULT = 128;
   localparam int COLS_DEFAULT = 128;

   localparam int MAX_OUT = 8;
   localparam int STEP_W  = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
   localparam int POS_W   = 6;
   localparam int IDX_W   = 3;

   typedef logic [2:0] scheme_type;
   typedef logic [2:0] shape_type;
   typedef logic [1:0] status_type;

   localparam scheme_type SCHEME_UNDEF      = 3'd0;
   localparam scheme_type SCHEME_RECT       = 3'd1;
   localparam scheme_type SCHEME_RECT_ROW   = 3'd2;
   localparam scheme_type SCHEME_RECT_COL   = 3'd3;
   localparam scheme_type SCHEME_ROW_COL    = 3'd4;
   localparam scheme_type SCHEME_RECT_TRECT = 3'd5;

   localparam shape_type SHAPE_RECT      = 3'd0;
   localparam shape_type SHAPE_ROW       = 3'd1;
   localparam shape_type SHAPE_MAIN_DIAG = 3'd2;
   localparam shape_type SHAPE_SEC_DIAG  = 3'd3;
   localparam shape_type SHAPE_COL       = 3'd4;
   localparam shape_type SHAPE_TRECT     = 3'd5;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_OOB       = 2'd1;
   localparam status_type STATUS_NO_SCHEME = 2'd2;
   localparam status_type STATUS_NO_SHAPE  = 2'd3;

   function automatic logic scheme_valid(input scheme_type scheme);
      return (scheme == SCHEME_RECT) || (scheme == SCHEME_RECT_ROW) ||
             (scheme == SCHEME_RECT_COL) || (scheme == SCHEME_ROW_COL) ||
             (scheme == SCHEME_RECT_TRECT);
   endfunction

   function automatic logic shape_ok(input scheme_type scheme, input shape_type shape);
      logic ok;
      unique case (scheme)
         SCHEME_RECT: begin
            ok = (shape == SHAPE_RECT);
         end
         SCHEME_RECT_ROW: begin
            ok = (shape == SHAPE_RECT) || (shape == SHAPE_ROW) ||
                 (shape == SHAPE_MAIN_DIAG) || (shape == SHAPE_SEC_DIAG);
         end
         SCHEME_RECT_COL: begin
            ok = (shape == SHAPE_RECT) || (shape == SHAPE_COL) ||
                 (shape == SHAPE_MAIN_DIAG) || (shape == SHAPE_SEC_DIAG);
         end
         SCHEME_ROW_COL: begin
            ok = (shape == SHAPE_RECT) || (shape == SHAPE_ROW) || (shape == SHAPE_COL);
         end
         SCHEME_RECT_TRECT: begin
            ok = (shape == SHAPE_RECT) || (shape == SHAPE_TRECT);
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      return ok;
   endfunction

   // Quotient of an 8-bit value by a small constant, using its 17-bit reciprocal scaled by 2^16.
   function automatic logic [7:0] quo_const(input logic [7:0] x, input logic [16:0] recip);
      logic [24:0] prod;
      prod = 25'(x) * 25'(recip);
      return prod[23:16];
   endfunction

   function automatic logic [7:0] mod_const(input logic [7:0] x, input logic [3:0] d,
                                            input logic [16:0] recip);
      logic [7:0] q;
      q = quo_const(x, recip);
      return x - 8'(q * {4'b0000, d});
   endfunction

endpackage

// File: rtl/prf_block_access_address_gen.sv
// Block-access address generator for a polymorphic register file. Each request on the req
// channel names a start element and an access shape; the block answers with one rsp
// transaction per element (P*Q of them, in position order, at most 8 per request; a longer
// access goes on with the next request), each carrying the element coordinates, the memory
// module and in-module address under the scheme in the csr register, and a status. An
// undefined scheme or an unsupported shape gives a single transaction marked last. An
// out-of-bounds element carries zero module and address fields. Results leave one per
// cycle from the output register while rsp_tready stays high. The next request is accepted
// in the cycle its predecessor's final result is produced. The scheme register must be
// written only while no request is in progress.
module prf_block_access_address_gen #(
   parameter int P    = pbaag_pkg::P_DEFAULT,
   parameter int Q    = pbaag_pkg::Q_DEFAULT,
   parameter int ROWS = pbaag_pkg::ROWS_DEFAULT,
   parameter int COLS = pbaag_pkg::COLS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_wdata,    // mapping_scheme
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // base_row[6:0], base_col[13:7], zero fill
   input  logic [2:0]  req_tuser,    // access_shape
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,    // position, elem_row, elem_col, module_row,
                                     // module_col, in_module_addr, zero fill
   output logic [1:0]  rsp_tuser,    // status
   output logic        rsp_tlast
);

   localparam logic [16:0] RECIP_P    = 17'((65536 + P - 1) / P);
   localparam logic [16:0] RECIP_Q    = 17'((65536 + Q - 1) / Q);
   localparam logic [3:0]  P_D        = 4'(P);
   localparam logic [3:0]  Q_D        = 4'(Q);
   localparam logic [13:0] ROW_STRIDE = 14'(COLS / Q);

   pbaag_pkg::scheme_type scheme_ff;
   logic                  active_ff, active_in;
   logic [pbaag_pkg::POS_W-1:0]  k_ff, k_in;
   logic [pbaag_pkg::IDX_W-1:0]  i_ff, i_in, j_ff, j_in;
   logic [pbaag_pkg::STEP_W-1:0] n_ff, n_in;
   logic [6:0]            held_row_ff, held_row_in, held_col_ff, held_col_in;
   pbaag_pkg::shape_type  held_shape_ff, held_shape_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [47:0]           rsp_data_ff, rsp_data_in;
   pbaag_pkg::status_type rsp_status_ff, rsp_status_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  load_w, req_fire_w, request_ok_w, last_w, step_done_w;
   logic [5:0]            di_w;
   logic [8:0]            dj_w, elem_col_w;
   logic [7:0]            elem_row_w, rx_w, cx_w, rq_w, rp_w, cq_w, cm_w;
   logic [7:0]            mr_w, mc_w;
   logic                  in_bounds_w;
   logic [13:0]           addr_w;

   assign request_ok_w = pbaag_pkg::scheme_valid(scheme_ff) &&
                         pbaag_pkg::shape_ok(scheme_ff, held_shape_ff);
   assign load_w       = active_ff && (!rsp_valid_ff || rsp_tready);
   assign last_w       = !request_ok_w ||
                         ((i_ff == pbaag_pkg::IDX_W'(P - 1)) &&
                          (j_ff == pbaag_pkg::IDX_W'(Q - 1)));
   assign step_done_w  = last_w || (n_ff == pbaag_pkg::STEP_W'(pbaag_pkg::MAX_OUT - 1));
   assign req_tready   = !active_ff || (load_w && step_done_w);
   assign req_fire_w   = req_tvalid && req_tready;

   always_comb begin
      unique case (held_shape_ff)
         pbaag_pkg::SHAPE_RECT: begin
            di_w = 6'(i_ff);
            dj_w = 9'(j_ff);
         end
         pbaag_pkg::SHAPE_ROW: begin
            di_w = '0;
            dj_w = 9'(k_ff);
         end
         pbaag_pkg::SHAPE_MAIN_DIAG: begin
            di_w = k_ff;
            dj_w = 9'(k_ff);
         end
         pbaag_pkg::SHAPE_SEC_DIAG: begin
            di_w = k_ff;
            dj_w = 9'(0) - 9'(k_ff);
         end
         pbaag_pkg::SHAPE_COL: begin
            di_w = k_ff;
            dj_w = '0;
         end
         default: begin
            di_w = 6'(j_ff);
            dj_w = 9'(i_ff);
         end
      endcase
   end

   assign elem_row_w  = {1'b0, held_row_ff} + {2'b00, di_w};
   assign elem_col_w  = {2'b00, held_col_ff} + dj_w;
   assign in_bounds_w = (elem_row_w < 8'(ROWS)) && !elem_col_w[8] &&
                        (elem_col_w[7:0] < 8'(COLS));

   assign rx_w = {1'b0, elem_row_w[6:0]};
   assign cx_w = {1'b0, elem_col_w[6:0]};
   assign rq_w = pbaag_pkg::quo_const(rx_w, RECIP_P);
   assign rp_w = rx_w - 8'(rq_w * {4'b0000, P_D});
   assign cq_w = pbaag_pkg::quo_const(cx_w, RECIP_Q);
   assign cm_w = cx_w - 8'(cq_w * {4'b0000, Q_D});

   always_comb begin
      unique case (scheme_ff)
         pbaag_pkg::SCHEME_RECT_ROW: begin
            mr_w = pbaag_pkg::mod_const(rx_w + cq_w, P_D, RECIP_P);
            mc_w = cm_w;
         end
         pbaag_pkg::SCHEME_RECT_COL: begin
            mr_w = rp_w;
            mc_w = pbaag_pkg::mod_const(rq_w + cx_w, Q_D, RECIP_Q);
         end
         pbaag_pkg::SCHEME_ROW_COL: begin
            mr_w = pbaag_pkg::mod_const(rx_w + cq_w, P_D, RECIP_P);
            mc_w = pbaag_pkg::mod_const(rq_w + cx_w, Q_D, RECIP_Q);
         end
         pbaag_pkg::SCHEME_RECT_TRECT: begin
            if (P < Q) begin
               mr_w = rp_w;
               mc_w = pbaag_pkg::mod_const(rx_w - rp_w + cx_w, Q_D, RECIP_Q);
            end else begin
               mr_w = pbaag_pkg::mod_const(rx_w + cx_w - cm_w, P_D, RECIP_P);
               mc_w = cm_w;
            end
         end
         default: begin
            mr_w = rp_w;
            mc_w = cm_w;
         end
      endcase
   end

   assign addr_w = 14'(rq_w) * ROW_STRIDE + 14'(cq_w);

   always_comb begin
      active_in     = active_ff;
      k_in          = k_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      n_in          = n_ff;
      held_row_in   = held_row_ff;
      held_col_in   = held_col_ff;
      held_shape_in = held_shape_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      if (load_w) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = last_w;
         if (!pbaag_pkg::scheme_valid(scheme_ff)) begin
            rsp_data_in   = '0;
            rsp_status_in = pbaag_pkg::STATUS_NO_SCHEME;
         end else if (!request_ok_w) begin
            rsp_data_in   = '0;
            rsp_status_in = pbaag_pkg::STATUS_NO_SHAPE;
         end else if (in_bounds_w) begin
            rsp_data_in   = {5'b00000, addr_w, mc_w[2:0], mr_w[2:0], elem_col_w,
                             elem_row_w, k_ff};
            rsp_status_in = pbaag_pkg::STATUS_OK;
         end else begin
            rsp_data_in   = {25'b0, elem_col_w, elem_row_w, k_ff};
            rsp_status_in = pbaag_pkg::STATUS_OOB;
         end

         if (last_w) begin
            k_in = '0;
            i_in = '0;
            j_in = '0;
         end else begin
            k_in = k_ff + 1'b1;
            if (j_ff == pbaag_pkg::IDX_W'(Q - 1)) begin
               j_in = '0;
               i_in = i_ff + 1'b1;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end

         if (step_done_w) begin
            active_in = 1'b0;
         end else begin
            n_in = n_ff + 1'b1;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_fire_w) begin
         active_in = 1'b1;
         n_in      = '0;
         if (k_in == '0) begin
            held_row_in   = req_tdata[6:0];
            held_col_in   = req_tdata[13:7];
            held_shape_in = req_tuser;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scheme_ff     <= pbaag_pkg::SCHEME_UNDEF;
         active_ff     <= 1'b0;
         k_ff          <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
         n_ff          <= '0;
         held_row_ff   <= '0;
         held_col_ff   <= '0;
         held_shape_ff <= pbaag_pkg::SHAPE_RECT;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            scheme_ff <= csr_wdata;
         end
         active_ff     <= active_in;
         k_ff          <= k_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         n_ff          <= n_in;
         held_row_ff   <= held_row_in;
         held_col_ff   <= held_col_in;
         held_shape_ff <= held_shape_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_error_result_is_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ((rsp_status_ff == pbaag_pkg::STATUS_NO_SCHEME) ||
                       (rsp_status_ff == pbaag_pkg::STATUS_NO_SHAPE))
      |-> rsp_last_ff && (rsp_data_ff == '0))
      else $error("Error result carries data or lacks last.");

   a_counter_consistent: assert property (@(posedge clock) disable iff (reset)
      32'(k_ff) == 32'(i_ff) * Q + 32'(j_ff))
      else $error("Element counter disagrees with its row and column indices.");

   a_last_clears_counter: assert property (@(posedge clock) disable iff (reset)
      load_w && last_w |=> (k_ff == '0) && (i_ff == '0) && (j_ff == '0))
      else $error("Element counter not cleared after the final result.");

   a_position_matches: assert property (@(posedge clock) disable iff (reset)
      load_w && request_ok_w |=> rsp_data_ff[5:0] == $past(k_ff))
      else $error("Result position does not match the element counter.");

endmodule
